>>> src/elf_note_record_deframer_macros.svh
// Assertion helpers for the note record deframer checker.
// Each macro expects clk and arst_n in scope.
`ifndef ELF_NOTE_RECORD_DEFRAMER_MACROS_SVH
`define ELF_NOTE_RECORD_DEFRAMER_MACROS_SVH

// Same-cycle implication.
`define ENRD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");

// Next-cycle implication.
`define ENRD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

`endif

>>> src/enrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enrd_pkg
// Shared types and constants of the note record deframer.
// ----------------------------------------------------------------------------
package enrd_pkg;

	localparam logic [2:0] ROLE_HEADER    = 3'd0;
	localparam logic [2:0] ROLE_NAME      = 3'd1;
	localparam logic [2:0] ROLE_NAME_PAD  = 3'd2;
	localparam logic [2:0] ROLE_DESC      = 3'd3;
	localparam logic [2:0] ROLE_DESC_PAD  = 3'd4;

	// Offset of the final header byte (header is 12 bytes)
	localparam logic [3:0] HDR_LAST = 4'd11;

	typedef struct packed {
		logic [7:0]  byte_value;
		logic [2:0]  byte_role;
		logic [31:0] field_offset;
		logic [31:0] note_index;
		logic        header_valid;
		logic [31:0] name_size;
		logic [31:0] desc_size;
		logic [31:0] note_type;
		logic        record_end;
		logic        section_end;
		logic        status;
	} result_t;

endpackage

>>> src/elf_note_record_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elf_note_record_deframer
// Splits the bytes of an ELF note section into records and tags every byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one section byte per beat, with
//   last_byte set on the final byte of the section.
//   Output channel (out_valid / out_stall): one tagged beat per input beat,
//   in order: role, offset within the part, record index, header words,
//   record_end, section_end and a truncation status on the last byte.
//   Config channel (cfg_valid / cfg_ready): writes big_endian, the byte
//   order of the header words; cfg_ready is always high. Write it only
//   while no beats are in flight.
// Output register and throughput:
//   A beat accepted at an edge enters the output register at that edge,
//   or the skid register while a result is held. One beat per cycle is
//   sustained while out_stall is low; record counters advance per byte.
// Reset:
//   arst_n clears all record state, the output and skid stages, and sets
//   big_endian to little-endian.
// Backpressure:
//   When out_stall holds a pending result, one more beat is taken into a
//   skid register; in_stall then rises until the output drains.
// ----------------------------------------------------------------------------
module elf_note_record_deframer (
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        big_endian,
	// output beats
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  byte_value,
	output logic [2:0]  byte_role,
	output logic [31:0] field_offset,
	output logic [31:0] note_index,
	output logic        header_valid,
	output logic [31:0] name_size,
	output logic [31:0] desc_size,
	output logic [31:0] note_type,
	output logic        record_end,
	output logic        section_end,
	output logic        status
);

	logic              big_endian_q;
	logic              accept;
	logic              out_pop;
	logic              out_valid_q;
	logic              skid_valid_q;
	enrd_pkg::result_t res;
	enrd_pkg::result_t out_q;
	enrd_pkg::result_t skid_q;

	// config register: always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			big_endian_q <= big_endian;
		end
	end

	// stall input only when the skid stage is occupied
	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !in_stall;
	assign out_pop  = out_valid_q && !out_stall;

	enrd_tracker u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.big_endian (big_endian_q),
		.res        (res)
	);

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_pop || !out_valid_q) begin
				// advance: skid first, else the fresh beat
				out_valid_q  <= skid_valid_q || accept;
				skid_valid_q <= 1'b0;
			end else if (accept) begin
				// hold output, park the new beat
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_pop || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : res;
		end
		if (accept && out_valid_q && !out_pop) begin
			skid_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign byte_value   = out_q.byte_value;
	assign byte_role    = out_q.byte_role;
	assign field_offset = out_q.field_offset;
	assign note_index   = out_q.note_index;
	assign header_valid = out_q.header_valid;
	assign name_size    = out_q.name_size;
	assign desc_size    = out_q.desc_size;
	assign note_type    = out_q.note_type;
	assign record_end   = out_q.record_end;
	assign section_end  = out_q.section_end;
	assign status       = out_q.status;

endmodule

>>> src/enrd_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enrd_tracker
// Record state of the deframer: header capture, part counters, record count.
// Produces the tagged result of the current byte and advances on accept.
// ----------------------------------------------------------------------------
module enrd_tracker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic              big_endian,
	output enrd_pkg::result_t res
);

	logic [2:0]  phase_q;
	logic [3:0]  hdr_cnt_q;
	logic [31:0] name_len_q;
	logic [31:0] desc_len_q;
	logic [31:0] rec_type_q;
	logic [31:0] left_q;
	logic [31:0] offs_q;
	logic [31:0] rec_cnt_q;

	logic        hdr;
	logic [31:0] cur_word;
	logic [31:0] put_word;
	logic [31:0] name_n;
	logic [31:0] desc_n;
	logic [31:0] type_n;
	logic        hvalid;
	logic [31:0] left_dec;
	logic        part_done;
	logic        found;
	logic [2:0]  nq;
	logic [31:0] nlen;
	logic        rend;

	// merge the incoming byte into the header word it belongs to
	always_comb begin
		hdr = (phase_q == enrd_pkg::ROLE_HEADER);
		case (hdr_cnt_q[3:2])
			2'd0:    cur_word = name_len_q;
			2'd1:    cur_word = desc_len_q;
			default: cur_word = rec_type_q;
		endcase
		if (big_endian) begin
			put_word = {cur_word[23:0], data_byte};
		end else begin
			put_word = cur_word | (32'(data_byte) << {hdr_cnt_q[1:0], 3'b000});
		end
		name_n = name_len_q;
		desc_n = desc_len_q;
		type_n = rec_type_q;
		if (hdr) begin
			case (hdr_cnt_q[3:2])
				2'd0:    name_n = put_word;
				2'd1:    desc_n = put_word;
				default: type_n = put_word;
			endcase
		end
	end

	// find the first non-empty part after the current one
	always_comb begin
		logic [31:0] lens [1:4];
		lens[1] = name_n;
		lens[2] = {30'd0, 2'(0 - name_n[1:0])};
		lens[3] = desc_n;
		lens[4] = {30'd0, 2'(0 - desc_n[1:0])};
		found = 1'b0;
		nq    = enrd_pkg::ROLE_HEADER;
		nlen  = '0;
		for (int i = 1; i <= 4; i++) begin
			if (!found && (i > int'(phase_q)) && (lens[i] != '0)) begin
				found = 1'b1;
				nq    = 3'(i);
				nlen  = lens[i];
			end
		end
	end

	assign hvalid    = hdr ? (hdr_cnt_q == enrd_pkg::HDR_LAST) : 1'b1;
	assign left_dec  = left_q - 32'd1;
	assign part_done = hdr ? hvalid : (left_dec == '0);
	assign rend      = part_done && !found;

	always_comb begin
		res.byte_value   = data_byte;
		res.byte_role    = phase_q;
		res.field_offset = hdr ? {28'd0, hdr_cnt_q} : offs_q;
		res.note_index   = rec_cnt_q;
		res.header_valid = hvalid;
		res.name_size    = hvalid ? name_n : '0;
		res.desc_size    = hvalid ? desc_n : '0;
		res.note_type    = hvalid ? type_n : '0;
		res.record_end   = rend;
		res.section_end  = last_byte;
		// a partial header at section end is dropped silently
		res.status       = last_byte && !rend && (!hdr || hvalid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= enrd_pkg::ROLE_HEADER;
			hdr_cnt_q  <= '0;
			name_len_q <= '0;
			desc_len_q <= '0;
			rec_type_q <= '0;
			left_q     <= '0;
			offs_q     <= '0;
			rec_cnt_q  <= '0;
		end else if (accept) begin
			if (last_byte || rend) begin
				// clear record; restart count at section end
				phase_q    <= enrd_pkg::ROLE_HEADER;
				hdr_cnt_q  <= '0;
				name_len_q <= '0;
				desc_len_q <= '0;
				rec_type_q <= '0;
				left_q     <= '0;
				offs_q     <= '0;
				rec_cnt_q  <= last_byte ? '0 : rec_cnt_q + 32'd1;
			end else begin
				name_len_q <= name_n;
				desc_len_q <= desc_n;
				rec_type_q <= type_n;
				if (hdr) begin
					hdr_cnt_q <= hdr_cnt_q + 4'd1;
				end
				if (part_done) begin
					phase_q <= nq;
					left_q  <= nlen;
					offs_q  <= '0;
				end else if (!hdr) begin
					left_q <= left_dec;
					offs_q <= offs_q + 32'd1;
				end
			end
		end
	end

endmodule

>>> src/enrd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enrd_checker
// Port-level checks of the note record deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "elf_note_record_deframer_macros.svh"

module enrd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  byte_value,
	input logic [2:0]  byte_role,
	input logic [31:0] field_offset,
	input logic        header_valid,
	input logic [31:0] name_size,
	input logic [31:0] desc_size,
	input logic [31:0] note_type,
	input logic        record_end,
	input logic        section_end,
	input logic        status
);

	// stalled beat holds
	`ENRD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(byte_value))

	// header words become valid exactly on the last header byte
	`ENRD_ASSERT_NOW(a_hdr_valid, out_valid && byte_role == enrd_pkg::ROLE_HEADER, header_valid == (field_offset == 32'd11))

	// body bytes always follow a complete header
	`ENRD_ASSERT_NOW(a_body_hdr, out_valid && byte_role != enrd_pkg::ROLE_HEADER, header_valid)

	// header words read zero until the header is complete
	`ENRD_ASSERT_NOW(a_hdr_zero, out_valid && !header_valid, name_size == 32'd0 && desc_size == 32'd0 && note_type == 32'd0)

	// truncation only on the section's last byte of an unfinished record
	`ENRD_ASSERT_NOW(a_trunc, out_valid && status, section_end && !record_end)

endmodule

bind elf_note_record_deframer enrd_checker u_enrd_checker (.*);

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the note record deframer. Builds note sections
// (well-formed records, cut-off records, partial headers and raw noise) in
// both header byte orders. Feeds them one byte per beat with random gaps and
// output stalls. Checks every tagged output beat against an in-bench model
// of the record parser.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_REPORTS    = 10;
	localparam int LONG_HOLD      = 300;

	// Drive every input to a known value from time zero.
	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte   = 8'd0;
	logic        last_byte   = 1'b0;
	logic        cfg_valid   = 1'b0;
	logic        cfg_ready;
	logic        big_endian  = 1'b0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [7:0]  byte_value;
	logic [2:0]  byte_role;
	logic [31:0] field_offset;
	logic [31:0] note_index;
	logic        header_valid;
	logic [31:0] name_size;
	logic [31:0] desc_size;
	logic [31:0] note_type;
	logic        record_end;
	logic        section_end;
	logic        status;

	elf_note_record_deframer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.big_endian   (big_endian),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.byte_value   (byte_value),
		.byte_role    (byte_role),
		.field_offset (field_offset),
		.note_index   (note_index),
		.header_valid (header_valid),
		.name_size    (name_size),
		.desc_size    (desc_size),
		.note_type    (note_type),
		.record_end   (record_end),
		.section_end  (section_end),
		.status       (status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Parser model: a private copy of the record state and byte order.
	// ------------------------------------------------------------------
	logic [2:0]  cur_part;
	logic [3:0]  hdr_count;
	logic [31:0] hdr_name_len;
	logic [31:0] hdr_desc_len;
	logic [31:0] hdr_type;
	logic [33:0] part_left;
	logic [33:0] part_offset;
	logic [31:0] records_done;
	logic        order_big;

	enrd_pkg::result_t expected_tags[$];

	// Stimulus knobs and run statistics.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;
	int mismatch_count = 0;
	int beats_checked = 0;
	int records_closed = 0;
	int truncations   = 0;
	int sections_sent = 0;

	function automatic logic [1:0] pad_of(logic [31:0] len);
		return 2'd0 - len[1:0];
	endfunction

	function automatic void clear_record_state();
		cur_part     = enrd_pkg::ROLE_HEADER;
		hdr_count    = '0;
		hdr_name_len = '0;
		hdr_desc_len = '0;
		hdr_type     = '0;
		part_left    = '0;
		part_offset  = '0;
	endfunction

	function automatic logic [33:0] part_length_of(logic [2:0] p);
		case (p)
			enrd_pkg::ROLE_NAME:     return 34'(hdr_name_len);
			enrd_pkg::ROLE_NAME_PAD: return 34'(pad_of(hdr_name_len));
			enrd_pkg::ROLE_DESC:     return 34'(hdr_desc_len);
			enrd_pkg::ROLE_DESC_PAD: return 34'(pad_of(hdr_desc_len));
			default:                 return '0;
		endcase
	endfunction

	// Advance to the first non-empty part after 'from'; report whether one exists.
	function automatic bit enter_next_part(logic [2:0] from);
		logic [33:0] len;
		for (int q = int'(from) + 1; q <= int'(enrd_pkg::ROLE_DESC_PAD); q++) begin
			len = part_length_of(3'(q));
			if (len != 0) begin
				cur_part    = 3'(q);
				part_left   = len;
				part_offset = '0;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [31:0] merge_header_byte(logic [31:0] word, logic [1:0] pos,
		logic [7:0] b);
		if (order_big)
			return {word[23:0], b};
		return word | (32'(b) << (8 * pos));
	endfunction

	// Tag one section byte and advance the record state.
	function automatic enrd_pkg::result_t tag_byte(logic [7:0] b, logic last);
		enrd_pkg::result_t t;
		logic [3:0]  k;
		logic        in_header;
		logic        hdr_full;
		logic        closes;
		logic [33:0] offset;
		t = '0;
		in_header = (cur_part == enrd_pkg::ROLE_HEADER);
		closes = 1'b0;
		t.byte_value  = b;
		t.byte_role   = cur_part;
		t.note_index  = records_done;
		t.section_end = last;
		if (in_header) begin
			k = hdr_count;
			offset = 34'(k);
			case (k[3:2])
				2'd0:    hdr_name_len = merge_header_byte(hdr_name_len, k[1:0], b);
				2'd1:    hdr_desc_len = merge_header_byte(hdr_desc_len, k[1:0], b);
				default: hdr_type     = merge_header_byte(hdr_type, k[1:0], b);
			endcase
			hdr_count = k + 4'd1;
			hdr_full = (k == enrd_pkg::HDR_LAST);
			// A record with empty name and descriptor closes on its last header byte.
			if (hdr_full && !enter_next_part(enrd_pkg::ROLE_HEADER))
				closes = 1'b1;
		end else begin
			offset = part_offset;
			hdr_full = 1'b1;
			part_offset = part_offset + 34'd1;
			if (part_left != 0)
				part_left = part_left - 34'd1;
			if (part_left == 0 && !enter_next_part(cur_part))
				closes = 1'b1;
		end
		t.field_offset = offset[31:0];
		t.header_valid = hdr_full;
		if (hdr_full) begin
			t.name_size = hdr_name_len;
			t.desc_size = hdr_desc_len;
			t.note_type = hdr_type;
		end
		t.record_end = closes;
		// A partial header at the section end is dropped silently.
		t.status = last && !closes && (!in_header || hdr_full);
		if (closes) begin
			records_done = records_done + 32'd1;
			clear_record_state();
		end
		if (last) begin
			records_done = '0;
			clear_record_state();
		end
		return t;
	endfunction

	function automatic string format_tag(enrd_pkg::result_t t);
		return $sformatf({"val=%h role=%0d off=%h idx=%h hv=%b nsz=%h dsz=%h typ=%h ",
			"rend=%b send=%b st=%b"}, t.byte_value, t.byte_role, t.field_offset,
			t.note_index, t.header_valid, t.name_size, t.desc_size, t.note_type,
			t.record_end, t.section_end, t.status);
	endfunction

	function automatic string diff_fields(enrd_pkg::result_t w, enrd_pkg::result_t g);
		string s = "";
		if (w.byte_value   !== g.byte_value)   s = {s, " byte_value"};
		if (w.byte_role    !== g.byte_role)    s = {s, " byte_role"};
		if (w.field_offset !== g.field_offset) s = {s, " field_offset"};
		if (w.note_index   !== g.note_index)   s = {s, " note_index"};
		if (w.header_valid !== g.header_valid) s = {s, " header_valid"};
		if (w.name_size    !== g.name_size)    s = {s, " name_size"};
		if (w.desc_size    !== g.desc_size)    s = {s, " desc_size"};
		if (w.note_type    !== g.note_type)    s = {s, " note_type"};
		if (w.record_end   !== g.record_end)   s = {s, " record_end"};
		if (w.section_end  !== g.section_end)  s = {s, " section_end"};
		if (w.status       !== g.status)       s = {s, " status"};
		return s;
	endfunction

	// ------------------------------------------------------------------
	// Output side: check each accepted beat against the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		enrd_pkg::result_t want;
		enrd_pkg::result_t got;
		string   diffs;
		if (arst_n && out_valid && !out_stall) begin
			got = {byte_value, byte_role, field_offset, note_index, header_valid,
				name_size, desc_size, note_type, record_end, section_end, status};
			beats_checked++;
			if (got.record_end === 1'b1)
				records_closed++;
			if (got.status === 1'b1)
				truncations++;
			if (expected_tags.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected output beat: %s", format_tag(got));
			end else begin
				want = expected_tags.pop_front();
				diffs = diff_fields(want, got);
				if (diffs != "") begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("mismatch on beat %0d:%s", beats_checked, diffs);
						$display("  expected %s", format_tag(want));
						$display("  actual   %s", format_tag(got));
					end
				end
			end
		end
	end

	// Receiver stall: a long hold when requested, else a random stall.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Watchdog: end the run when no channel moves a beat for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d beats outstanding", expected_tags.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Offer one byte, idling first at random; predict it once accepted.
	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (in_stall);
		expected_tags.push_back(tag_byte(b, last));
	endtask

	task automatic send_section(ref logic [7:0] sec[$]);
		foreach (sec[i])
			send_byte(sec[i], i == sec.size() - 1);
		sections_sent++;
	endtask

	// Drop valid, wait for every expected beat, then let the pipeline settle.
	task automatic drain_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_tags.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_byte_order(input logic be);
		@(negedge clk);
		cfg_valid  <= 1'b1;
		big_endian <= be;
		do @(posedge clk); while (!cfg_ready);
		order_big = be;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Section builders
	// ------------------------------------------------------------------
	task automatic add_header(ref logic [7:0] sec[$], input logic [31:0] nsz,
		input logic [31:0] dsz, input logic [31:0] typ);
		logic [31:0] words [3];
		words = '{nsz, dsz, typ};
		foreach (words[w])
			for (int i = 0; i < 4; i++)
				sec.push_back(order_big ? words[w][31 - 8 * i -: 8] : words[w][8 * i +: 8]);
	endtask

	task automatic add_record(ref logic [7:0] sec[$], input logic [31:0] nsz,
		input logic [31:0] dsz, input logic [31:0] typ);
		add_header(sec, nsz, dsz, typ);
		repeat (nsz) sec.push_back(8'($urandom_range(255)));
		repeat (pad_of(nsz)) sec.push_back(8'($urandom_range(255)));
		repeat (dsz) sec.push_back(8'($urandom_range(255)));
		repeat (pad_of(dsz)) sec.push_back(8'($urandom_range(255)));
	endtask

	// Mostly empty or short bodies, sometimes a few dozen bytes.
	function automatic logic [31:0] pick_body_size();
		int roll;
		roll = $urandom_range(99);
		if (roll < 30)
			return 32'd0;
		if (roll < 85)
			return 32'($urandom_range(1, 8));
		return 32'($urandom_range(9, 40));
	endfunction

	task automatic build_random_section(ref logic [7:0] sec[$]);
		int kind;
		int records;
		kind = $urandom_range(99);
		// Raw noise: random bytes parsed as whatever header they form.
		if (kind < 8) begin
			repeat ($urandom_range(1, 24)) sec.push_back(8'($urandom_range(255)));
			return;
		end
		records = $urandom_range(1, 4);
		for (int r = 0; r < records; r++) begin
			// Full-range header words; the section always cuts the body short.
			if ($urandom_range(99) < 5) begin
				add_header(sec, $urandom(), $urandom(), $urandom());
				repeat ($urandom_range(0, 12)) sec.push_back(8'($urandom_range(255)));
				return;
			end
			add_record(sec, pick_body_size(), pick_body_size(), $urandom());
		end
		// Cut some sections anywhere: in a header or in a body.
		if (kind < 24)
			sec = sec[0 : $urandom_range(0, sec.size() - 1)];
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Empty bodies, a partial header, all five roles, and a cut after a full header.
	task automatic test_directed_records();
		logic [7:0] sec[$];
		send_idle_pct = 20;
		recv_idle_pct = 20;
		write_byte_order(1'b0);
		add_record(sec, 32'd0, 32'd0, 32'hFFFF_FFFF);
		send_section(sec);
		sec.delete();
		add_header(sec, 32'd5, 32'd0, 32'd0);
		sec = sec[0:4];
		send_section(sec);
		drain_block();
		write_byte_order(1'b1);
		sec.delete();
		add_record(sec, 32'd1, 32'd1, 32'h8000_0001);
		add_header(sec, 32'd0, 32'd4, 32'h0000_0000);
		send_section(sec);
		drain_block();
	endtask

	task automatic test_random_sections(input int snd_pct, input int rcv_pct, input logic be,
		input int n_bytes);
		logic [7:0] sec[$];
		int sent = 0;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		write_byte_order(be);
		while (sent < n_bytes) begin
			sec.delete();
			build_random_section(sec);
			send_section(sec);
			sent += sec.size();
		end
		drain_block();
	endtask

	// Hold the output for a long stretch while bytes keep coming, so the
	// input side backs up and stalls.
	task automatic test_output_backpressure();
		logic [7:0] sec[$];
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_byte_order(1'b1);
		add_record(sec, 32'd7, 32'd13, $urandom());
		add_record(sec, 32'd0, 32'd22, $urandom());
		@(posedge clk);
		hold_left = LONG_HOLD;
		send_section(sec);
		drain_block();
	endtask

	initial begin
		order_big = 1'b0;
		records_done = '0;
		clear_record_state();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_records();
		test_random_sections(9, 75, 1'b0, 240);
		test_random_sections(9, 75, 1'b1, 240);
		test_random_sections(75, 9, 1'b1, 240);
		test_random_sections(75, 9, 1'b0, 240);
		test_random_sections(0, 0, 1'b0, 240);
		test_random_sections(0, 0, 1'b1, 240);
		test_output_backpressure();

		while (expected_tags.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		$display("Sent %0d sections in both byte orders; checked %0d beats.",
			sections_sent, beats_checked);
		$display("Saw %0d closed records and %0d truncated sections; %0d mismatches.",
			records_closed, truncations, mismatch_count);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> elf_note_record_deframer.f
+incdir+src
src/enrd_pkg.sv
src/enrd_tracker.sv
src/elf_note_record_deframer.sv
src/enrd_checker.sv
test/testbench.sv
